/* sv/kt_pkg.sv */
// Shared types, constants and helpers for the tilt Kalman filter.
package kt_pkg;

  localparam int unsigned DW = 32;
  localparam int unsigned ACCEL_W = 25;
  localparam int unsigned GYRO_W = 27;
  localparam int unsigned DT_W = 17;
  localparam int unsigned QA_W = 17;
  localparam int unsigned QB_W = 17;
  localparam int unsigned R_W = 23;
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned STEP_W = 4;

  localparam logic [1:0] REG_DT = 2'd0;
  localparam logic [1:0] REG_QA = 2'd1;
  localparam logic [1:0] REG_QB = 2'd2;
  localparam logic [1:0] REG_R = 2'd3;

  localparam logic [STEP_W-1:0] PRED_LAST = 4'd9;
  localparam logic [STEP_W-1:0] CORR_LAST = 4'd11;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_RATE0,
    OP_M_RDT,
    OP_A_ANG_PD0,
    OP_M_P11DT,
    OP_A_STEP11,
    OP_M_PD0DT,
    OP_A_PRED,
    OP_M_QBDT,
    OP_A_P11_ERR_E,
    OP_DIV0,
    OP_M_K1P01,
    OP_A_P11,
    OP_M_K0P01,
    OP_A_P01,
    OP_M_K1P00,
    OP_A_P10,
    OP_M_K0P00,
    OP_A_P00,
    OP_M_K0ERR,
    OP_A_ANG,
    OP_M_K1ERR,
    OP_A_BIAS
  } op_t;

  typedef struct packed {
    logic ld_in;
    op_t  op;
    logic div_start;
    logic div_sel;
    logic k_ld;
    logic k_sel;
    logic ld_out;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } status_t;

  function automatic op_t pred_op(input logic [STEP_W-1:0] step);
    op_t o;
    case (step)
      4'd0:    o = OP_RATE0;
      4'd1:    o = OP_M_RDT;
      4'd2:    o = OP_A_ANG_PD0;
      4'd3:    o = OP_M_P11DT;
      4'd4:    o = OP_A_STEP11;
      4'd5:    o = OP_M_PD0DT;
      4'd6:    o = OP_A_PRED;
      4'd7:    o = OP_M_QBDT;
      4'd8:    o = OP_A_P11_ERR_E;
      4'd9:    o = OP_DIV0;
      default: o = OP_NONE;
    endcase
    return o;
  endfunction

  function automatic op_t corr_op(input logic [STEP_W-1:0] step);
    op_t o;
    case (step)
      4'd0:    o = OP_M_K1P01;
      4'd1:    o = OP_A_P11;
      4'd2:    o = OP_M_K0P01;
      4'd3:    o = OP_A_P01;
      4'd4:    o = OP_M_K1P00;
      4'd5:    o = OP_A_P10;
      4'd6:    o = OP_M_K0P00;
      4'd7:    o = OP_A_P00;
      4'd8:    o = OP_M_K0ERR;
      4'd9:    o = OP_A_ANG;
      4'd10:   o = OP_M_K1ERR;
      4'd11:   o = OP_A_BIAS;
      default: o = OP_NONE;
    endcase
    return o;
  endfunction

  function automatic logic signed [DW-1:0] sat64(input logic signed [63:0] v);
    logic signed [DW-1:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[DW-1:0];
    return r;
  endfunction

  function automatic logic signed [DW-1:0] sat35(input logic signed [34:0] v);
    logic signed [DW-1:0] r;
    if (v > 35'sd2147483647) r = 32'sh7fffffff;
    else if (v < -35'sd2147483648) r = 32'sh80000000;
    else r = v[DW-1:0];
    return r;
  endfunction

endpackage

/* sv/kt_if.sv */
// Request channel interfaces for samples and results.
interface kt_in_if;
  import kt_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [ACCEL_W-1:0] accel_angle;
  logic signed [GYRO_W-1:0]  gyro_rate;
  modport source (output valid, output accel_angle, output gyro_rate, input ready);
  modport sink (input valid, input accel_angle, input gyro_rate, output ready);
endinterface

interface kt_out_if;
  import kt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] angle_estimate;
  logic signed [DW-1:0] bias_estimate;
  logic signed [DW-1:0] corrected_rate;
  modport source (output valid, output angle_estimate, output bias_estimate,
                  output corrected_rate, input ready);
  modport sink (input valid, input angle_estimate, input bias_estimate,
                input corrected_rate, output ready);
endinterface

/* sv/kt_div.sv */
// Bit-serial restoring divider for the Kalman gains, saturating to 32 bits.
module kt_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [kt_pkg::DW-1:0] num,
  input  logic signed [kt_pkg::DW-1:0] den,
  output logic                         done,
  output logic signed [kt_pkg::DW-1:0] quo
);
  import kt_pkg::*;

  localparam int unsigned NW = DW + FRAC_BITS;
  localparam int unsigned QW = DW - 1;

  logic [DW-1:0]   mag;
  logic [NW-1:0]   nfull;
  logic [DW-1:0]   hi;
  logic            ovf;
  logic [QW-1:0]   rem_r, rem_nxt, low_r, q_r, den_r;
  logic [4:0]      cnt_r;
  logic            busy_r, done_r, neg_r, ovf_r;
  logic [DW-1:0]   trial;
  logic            ge;

  assign mag   = num[DW-1] ? DW'(-num) : DW'(num);
  assign nfull = {mag, {FRAC_BITS{1'b0}}};
  assign hi    = DW'(nfull[NW-1:QW]);
  assign ovf   = hi >= {1'b0, den[QW-1:0]};

  assign trial = {rem_r, low_r[QW-1]};
  assign ge    = trial >= {1'b0, den_r};
  always_comb begin
    rem_nxt = ge ? QW'(trial - {1'b0, den_r}) : trial[QW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= !ovf;
        done_r <= ovf;
      end else if (busy_r && cnt_r == 5'd0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= hi[QW-1:0];
      low_r <= nfull[QW-1:0];
      den_r <= den[QW-1:0];
      neg_r <= num[DW-1];
      ovf_r <= ovf;
      cnt_r <= 5'(QW - 1);
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      low_r <= {low_r[QW-2:0], 1'b0};
      q_r   <= {q_r[QW-2:0], ge};
      cnt_r <= cnt_r - 5'd1;
    end
  end

  assign done = done_r;
  always_comb begin
    if (ovf_r) quo = neg_r ? 32'sh80000000 : 32'sh7fffffff;
    else if (neg_r) quo = -$signed({1'b0, q_r});
    else quo = $signed({1'b0, q_r});
  end

endmodule

/* sv/kt_dp.sv */
// Datapath: filter state, one shared multiplier, saturating adders, divider.
module kt_dp #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  kt_pkg::cmd_t                      cmd,
  output kt_pkg::status_t                   status,
  input  logic signed [kt_pkg::ACCEL_W-1:0] accel_in,
  input  logic signed [kt_pkg::GYRO_W-1:0]  gyro_in,
  input  logic signed [kt_pkg::DW-1:0]      dt,
  input  logic signed [kt_pkg::DW-1:0]      qa,
  input  logic signed [kt_pkg::DW-1:0]      qb,
  input  logic signed [kt_pkg::DW-1:0]      rn,
  output logic signed [kt_pkg::DW-1:0]      angle_o,
  output logic signed [kt_pkg::DW-1:0]      bias_o,
  output logic signed [kt_pkg::DW-1:0]      rate_o
);
  import kt_pkg::*;

  localparam logic signed [DW-1:0] ONE_Q = DW'(1 << FRAC_BITS);
  localparam logic signed [63:0] HALF = 64'(1) << (FRAC_BITS - 1);

  logic signed [DW-1:0] ang_r, ang_nxt, bias_r, bias_nxt;
  logic signed [DW-1:0] p00_r, p00_nxt, p01_r, p01_nxt, p10_r, p10_nxt, p11_r, p11_nxt;
  logic signed [DW-1:0] accel_r, gyro_r, rate0_r, rate0_nxt, pd0_r, pd0_nxt;
  logic signed [DW-1:0] step11_r, step11_nxt, err_r, err_nxt, e_r, e_nxt;
  logic signed [DW-1:0] k0_r, k1_r, kval;
  logic signed [DW-1:0] mul_a, mul_b, mq, div_q;
  logic signed [63:0]   prod_r, rnd, shd;
  logic                 mul_en;

  kt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (cmd.div_sel ? p10_r : p00_r),
    .den   (e_r),
    .done  (status.div_done),
    .quo   (div_q)
  );

  assign rnd = prod_r + HALF;
  assign shd = rnd >>> FRAC_BITS;
  assign mq  = sat64(shd);

  always_comb begin
    mul_en = 1'b1;
    mul_a  = rate0_r;
    mul_b  = dt;
    case (cmd.op)
      OP_M_RDT:    begin mul_a = rate0_r; mul_b = dt;     end
      OP_M_P11DT:  begin mul_a = p11_r;   mul_b = dt;     end
      OP_M_PD0DT:  begin mul_a = pd0_r;   mul_b = dt;     end
      OP_M_QBDT:   begin mul_a = qb;      mul_b = dt;     end
      OP_M_K1P01:  begin mul_a = k1_r;    mul_b = p01_r;  end
      OP_M_K0P01:  begin mul_a = k0_r;    mul_b = p01_r;  end
      OP_M_K1P00:  begin mul_a = k1_r;    mul_b = p00_r;  end
      OP_M_K0P00:  begin mul_a = k0_r;    mul_b = p00_r;  end
      OP_M_K0ERR:  begin mul_a = k0_r;    mul_b = err_r;  end
      OP_M_K1ERR:  begin mul_a = k1_r;    mul_b = err_r;  end
      default:     mul_en = 1'b0;
    endcase
  end

  always_comb begin
    ang_nxt    = ang_r;
    bias_nxt   = bias_r;
    p00_nxt    = p00_r;
    p01_nxt    = p01_r;
    p10_nxt    = p10_r;
    p11_nxt    = p11_r;
    rate0_nxt  = rate0_r;
    pd0_nxt    = pd0_r;
    step11_nxt = step11_r;
    err_nxt    = err_r;
    e_nxt      = e_r;
    case (cmd.op)
      OP_RATE0:     rate0_nxt = sat35(35'(gyro_r) - 35'(bias_r));
      OP_A_ANG_PD0: begin
        ang_nxt = sat35(35'(ang_r) + 35'(mq));
        pd0_nxt = sat35(35'(qa) - 35'(p01_r) - 35'(p10_r));
      end
      OP_A_STEP11:  step11_nxt = mq;
      OP_A_PRED:    begin
        p00_nxt = sat35(35'(p00_r) + 35'(mq));
        p01_nxt = sat35(35'(p01_r) - 35'(step11_r));
        p10_nxt = sat35(35'(p10_r) - 35'(step11_r));
      end
      OP_A_P11_ERR_E: begin
        p11_nxt = sat35(35'(p11_r) + 35'(mq));
        err_nxt = sat35(35'(accel_r) - 35'(ang_r));
        e_nxt   = sat35(35'(rn) + 35'(p00_r));
      end
      OP_A_P11:     p11_nxt  = sat35(35'(p11_r) - 35'(mq));
      OP_A_P01:     p01_nxt  = sat35(35'(p01_r) - 35'(mq));
      OP_A_P10:     p10_nxt  = sat35(35'(p10_r) - 35'(mq));
      OP_A_P00:     p00_nxt  = sat35(35'(p00_r) - 35'(mq));
      OP_A_ANG:     ang_nxt  = sat35(35'(ang_r) + 35'(mq));
      OP_A_BIAS:    bias_nxt = sat35(35'(bias_r) + 35'(mq));
      default:      ;
    endcase
  end

  // gain is zero when the innovation variance is not positive
  assign kval = (e_r > 0) ? div_q : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_r  <= '0;
      bias_r <= '0;
      p00_r  <= ONE_Q;
      p01_r  <= '0;
      p10_r  <= '0;
      p11_r  <= ONE_Q;
    end else begin
      ang_r  <= ang_nxt;
      bias_r <= bias_nxt;
      p00_r  <= p00_nxt;
      p01_r  <= p01_nxt;
      p10_r  <= p10_nxt;
      p11_r  <= p11_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rate0_r  <= rate0_nxt;
    pd0_r    <= pd0_nxt;
    step11_r <= step11_nxt;
    err_r    <= err_nxt;
    e_r      <= e_nxt;
    if (cmd.ld_in) begin
      accel_r <= DW'(accel_in);
      gyro_r  <= DW'(gyro_in);
    end
    if (mul_en) prod_r <= mul_a * mul_b;
    if (cmd.k_ld) begin
      if (cmd.k_sel) k1_r <= kval;
      else k0_r <= kval;
    end
    if (cmd.ld_out) begin
      angle_o <= ang_r;
      bias_o  <= bias_r;
      rate_o  <= sat35(35'(gyro_r) - 35'(bias_r));
    end
  end

endmodule

/* sv/kt_ctrl.sv */
// Sequencer: steps the datapath through predict, gains and correct.
module kt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output kt_pkg::cmd_t    cmd,
  input  kt_pkg::status_t status
);
  import kt_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PRED = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_CORR = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                dsel_r, dsel_nxt;
  logic                out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    dsel_nxt      = dsel_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '{ld_in: 1'b0, op: OP_NONE, div_start: 1'b0, div_sel: 1'b0,
                      k_ld: 1'b0, k_sel: 1'b0, ld_out: 1'b0};
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.ld_in = 1'b1;
          step_nxt  = '0;
          state_nxt = ST_PRED;
        end
      end
      ST_PRED: begin
        cmd.op = pred_op(step_r);
        step_nxt = step_r + 1'b1;
        if (step_r == PRED_LAST) begin
          cmd.div_start = 1'b1;
          dsel_nxt      = 1'b0;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.k_sel = dsel_r;
        if (status.div_done) begin
          cmd.k_ld = 1'b1;
          if (!dsel_r) begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = 1'b1;
            dsel_nxt      = 1'b1;
          end else begin
            step_nxt  = '0;
            state_nxt = ST_CORR;
          end
        end
      end
      ST_CORR: begin
        cmd.op = corr_op(step_r);
        step_nxt = step_r + 1'b1;
        if (step_r == CORR_LAST) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.ld_out    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      dsel_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      dsel_r      <= dsel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    status.div_done |-> state_r == ST_DIV) else $error("divider done outside gain phase");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_out |-> (!out_valid_r || out_ready)) else $error("result overwritten");
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_PRED && step_r == '0))
    else $error("request accepted but not started");
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r) else $error("result dropped");
`endif

endmodule

/* sv/imu_tilt_kalman_filter.sv */
// Top level of the two-state tilt Kalman filter with APB register port.
// Each sample request, from acceptance to result, runs ten
// prediction steps through the shared multiplier, two 31-step bit-serial
// divisions for the gains (the bulk of the time), and twelve correction
// steps. A saturating gain skips its division. One sample is in work at a
// time; the next request is taken while the previous result waits.
module imu_tilt_kalman_filter #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  kt_in_if.sink                     in_ch,
  kt_out_if.source                  out_ch,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [kt_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import kt_pkg::*;

  localparam int unsigned ONE = 1 << FRAC_BITS;
  localparam logic [DT_W-1:0] RST_DT = DT_W'((12 * ONE + 500) / 1000);
  localparam logic [QA_W-1:0] RST_QA = QA_W'((ONE + 500) / 1000);
  localparam logic [QB_W-1:0] RST_QB = QB_W'((3 * ONE + 500) / 1000);
  localparam logic [R_W-1:0]  RST_R  = R_W'(ONE / 2);

  logic [DT_W-1:0] dt_r;
  logic [QA_W-1:0] qa_r;
  logic [QB_W-1:0] qb_r;
  logic [R_W-1:0]  r_r;
  logic            wr_en;
  logic [1:0]      reg_idx;
  cmd_t            cmd;
  status_t         status;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r <= RST_DT;
      qa_r <= RST_QA;
      qb_r <= RST_QB;
      r_r  <= RST_R;
    end else if (wr_en) begin
      case (reg_idx)
        REG_DT:  dt_r <= pwdata[DT_W-1:0];
        REG_QA:  qa_r <= pwdata[QA_W-1:0];
        REG_QB:  qb_r <= pwdata[QB_W-1:0];
        REG_R:   r_r  <= pwdata[R_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DT:  prdata = 32'(dt_r);
      REG_QA:  prdata = 32'(qa_r);
      REG_QB:  prdata = 32'(qb_r);
      REG_R:   prdata = 32'(r_r);
      default: prdata = '0;
    endcase
  end

  kt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .status    (status)
  );

  kt_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .status   (status),
    .accel_in (in_ch.accel_angle),
    .gyro_in  (in_ch.gyro_rate),
    .dt       ($signed(32'(dt_r))),
    .qa       ($signed(32'(qa_r))),
    .qb       ($signed(32'(qb_r))),
    .rn       ($signed(32'(r_r))),
    .angle_o  (out_ch.angle_estimate),
    .bias_o   (out_ch.bias_estimate),
    .rate_o   (out_ch.corrected_rate)
  );

endmodule

/* sim/tb_imu_tilt_kalman_filter.sv */
// Testbench for the tilt Kalman filter: random samples, register phases, scoreboard check.
`timescale 1ns / 100ps

module tb_imu_tilt_kalman_filter;
  import kt_pkg::*;

  typedef struct {
    logic signed [31:0] angle;
    logic signed [31:0] bias;
    logic signed [31:0] rate;
  } estimate_t;

  class tilt_scoreboard;
    int errors;
    estimate_t pending[$];
    logic signed [31:0] dt, qa, qb, rn;
    logic signed [31:0] ang, bia, p00, p01, p10, p11;

    function new();
      errors = 0;
      dt = 786; qa = 66; qb = 197; rn = 32768;
      ang = 0; bia = 0; p00 = 65536; p01 = 0; p10 = 0; p11 = 65536;
    endfunction

    function logic signed [31:0] clamp(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    function logic signed [31:0] qmul(input logic signed [31:0] a, input logic signed [31:0] b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b) + 64'sd32768;
      return clamp(p >>> 16);
    endfunction

    function logic signed [31:0] qdiv(input logic signed [31:0] n, input logic signed [31:0] d);
      logic signed [63:0] x;
      x = 64'(n) * 64'sd65536;
      return clamp(x / 64'(d));
    endfunction

    function void set_reg(input int idx, input logic [31:0] v);
      case (idx)
        0: dt = {15'd0, v[16:0]};
        1: qa = {15'd0, v[16:0]};
        2: qb = {15'd0, v[16:0]};
        3: rn = {9'd0, v[22:0]};
        default: ;
      endcase
    endfunction

    function void note_sample(input logic signed [24:0] acc, input logic signed [26:0] gyr);
      logic signed [31:0] r0, pd0, s11, err, e, k0, k1, t0, t1;
      estimate_t x;
      r0 = clamp(64'(gyr) - 64'(bia));
      ang = clamp(64'(ang) + 64'(qmul(r0, dt)));
      pd0 = clamp(64'(qa) - 64'(p01) - 64'(p10));
      s11 = qmul(p11, dt);
      p00 = clamp(64'(p00) + 64'(qmul(pd0, dt)));
      p01 = clamp(64'(p01) - 64'(s11));
      p10 = clamp(64'(p10) - 64'(s11));
      p11 = clamp(64'(p11) + 64'(qmul(qb, dt)));
      err = clamp(64'(acc) - 64'(ang));
      e = clamp(64'(rn) + 64'(p00));
      k0 = 0; k1 = 0;
      if (e > 0) begin
        k0 = qdiv(p00, e);
        k1 = qdiv(p10, e);
      end
      t0 = p00; t1 = p01;
      p00 = clamp(64'(p00) - 64'(qmul(k0, t0)));
      p01 = clamp(64'(p01) - 64'(qmul(k0, t1)));
      p10 = clamp(64'(p10) - 64'(qmul(k1, t0)));
      p11 = clamp(64'(p11) - 64'(qmul(k1, t1)));
      ang = clamp(64'(ang) + 64'(qmul(k0, err)));
      bia = clamp(64'(bia) + 64'(qmul(k1, err)));
      x.angle = ang; x.bias = bia;
      x.rate = clamp(64'(gyr) - 64'(bia));
      pending.push_back(x);
    endfunction

    function void check_result(input logic signed [31:0] a, input logic signed [31:0] b,
                               input logic signed [31:0] r);
      estimate_t x;
      if (pending.size() == 0) begin
        $error("unexpected result %0d %0d %0d", a, b, r);
        errors++;
        return;
      end
      x = pending.pop_front();
      if (a !== x.angle) begin
        $error("angle_estimate exp %0d got %0d", x.angle, a); errors++;
      end
      if (b !== x.bias) begin
        $error("bias_estimate exp %0d got %0d", x.bias, b); errors++;
      end
      if (r !== x.rate) begin
        $error("corrected_rate exp %0d got %0d", x.rate, r); errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  kt_in_if in_ch();
  kt_out_if out_ch();

  imu_tilt_kalman_filter DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  tilt_scoreboard sb = new();
  int idle_cycles;
  bit stim_done;
  bit hold_sink;
  int hold_len;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 0; psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_ch.valid = 0; in_ch.accel_angle = '0; in_ch.gyro_rate = '0;
    out_ch.ready = 0;
  end

  task automatic reg_write(input int idx, input logic [31:0] v);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= ADDR_W'(idx * 4); pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, v);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  task automatic send_sample(input logic signed [24:0] acc, input logic signed [26:0] gyr);
    int gap;
    gap = $urandom_range(0, 15);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1; in_ch.accel_angle <= acc; in_ch.gyro_rate <= gyr;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_sample(acc, gyr);
  endtask

  task automatic send_random(input int mode);
    logic signed [24:0] acc;
    logic signed [26:0] gyr;
    case (mode)
      0: begin
        acc = 25'(int'($urandom_range(0, 23592960)) - 11796480);
        gyr = 27'(int'($urandom_range(0, 131072000)) - 65536000);
      end
      1: begin
        acc = 25'(int'($urandom_range(0, 1310720)) - 655360);
        gyr = 27'(int'($urandom_range(0, 655360)) - 327680);
      end
      default: begin
        acc = 25'($urandom);
        gyr = 27'($urandom);
      end
    endcase
    send_sample(acc, gyr);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic phase(input int n);
    int mode;
    for (int i = 0; i < n; i++) begin
      mode = $urandom_range(0, 9);
      send_random(mode < 4 ? 0 : (mode < 8 ? 1 : 2));
    end
    drain();
  endtask

  initial begin
    stim_done = 0; hold_sink = 0; hold_len = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_sample(25'sd11796480, 27'sd65536000);
    send_sample(-25'sd11796480, -27'sd65536000);
    send_sample(25'sd0, 27'sd0);
    send_sample(25'h0FFFFFF, 27'h3FFFFFF);
    send_sample(25'h1000000, 27'h4000000);
    send_sample(25'h1FFFFFF, 27'h7FFFFFF);
    send_sample(25'sd65536, -27'sd65536);
    drain();
    reg_write(0, 32'd65536); reg_write(1, 32'd65536);
    reg_write(2, 32'd65536); reg_write(3, 32'd6553600);
    send_sample(25'sd11796480, -27'sd65536000);
    send_sample(-25'sd11796480, 27'sd65536000);
    send_sample(25'sd11796480, 27'sd65536000);
    drain();
    reg_write(0, 32'd1); reg_write(1, 32'd0); reg_write(2, 32'd0); reg_write(3, 32'd1);
    send_sample(25'sd11796480, 27'sd65536000);
    send_sample(-25'sd1, 27'sd1);
    drain();
    reg_write(3, 32'h007FFFFF); reg_write(0, 32'h0001FFFF);
    reg_write(1, 32'h0001FFFF); reg_write(2, 32'h0001FFFF);
    send_sample(25'sd1000, 27'sd2000);
    drain();
    reg_write(3, 32'd0);
    send_sample(25'sd100, 27'sd200);
    send_sample(-25'sd100, 27'sd0);
    drain();
    reg_write(0, 32'd786); reg_write(1, 32'd66); reg_write(2, 32'd197);
    reg_write(3, 32'd32768);
    hold_len = 400; hold_sink = 1;
    phase(200);
    for (int k = 0; k < 5; k++) begin
      reg_write(0, $urandom_range(1, 65536));
      reg_write(1, $urandom_range(0, 65536));
      reg_write(2, $urandom_range(0, 65536));
      reg_write(3, $urandom_range(1, 6553600));
      phase(110);
    end
    reg_write(0, 32'd1); reg_write(1, 32'd0); reg_write(2, 32'd0); reg_write(3, 32'd6553600);
    phase(40);
    stim_done = 1;
  end

  initial begin
    int w;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_sink) begin
        hold_sink = 0;
        out_ch.ready <= 0;
        repeat (hold_len) @(posedge clk);
      end
      w = $urandom_range(0, 15);
      if ($urandom_range(0, 3) == 0) w = 0;
      if (w != 0) begin
        out_ch.ready <= 0;
        repeat (w) @(posedge clk);
      end
      out_ch.ready <= 1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      sb.check_result(out_ch.angle_estimate, out_ch.bias_estimate, out_ch.corrected_rate);
    end
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (stim_done && sb.pending.size() == 0) begin
        if (sb.errors == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
      end
      if (idle_cycles >= 3000) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

endmodule
